/* rtl/nota_pkg.sv */
// ----------------------------------------------------------------------------
// nota_pkg
// Shared types, constants and small tables for the nematic order tensor
// accumulator: payload structs, register indexes and the divider interface.
// ----------------------------------------------------------------------------
package nota_pkg;

   localparam int POS_W     = 32;
   localparam int TYPE_W    = 8;
   localparam int Q_W       = 32;
   localparam int SUM_W     = 48;
   localparam int MAG_W     = 30;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int REM_W     = PROD_W + 2;
   localparam int DVD_W     = SUM_W + 1;
   localparam int QUO_W     = 32;
   localparam int STEP_W    = 6;
   localparam int MAX_MOLECULES = 65536;
   localparam int CNT_W     = 17;

   localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(QUO_W);
   localparam logic [STEP_W-1:0] AVG_STEPS   = STEP_W'(DVD_W);
   localparam logic [CNT_W-1:0]  MAX_COUNT   = CNT_W'(MAX_MOLECULES);
   localparam logic signed [SUM_W-1:0] ONE_THIRD_Q30 = SUM_W'(357913941);

   // Register indexes of the configuration port.
   localparam logic REG_MESOGEN_TYPE       = 1'b0;
   localparam logic REG_SITES_PER_MOLECULE = 1'b1;

   localparam logic [7:0] MESOGEN_RESET = 8'd1;
   localparam logic [7:0] GROUP_RESET   = 8'd2;

   typedef struct packed {
      logic [TYPE_W-1:0]        site_type;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic                     last_in_frame;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0] q_xx;
      logic signed [Q_W-1:0] q_xy;
      logic signed [Q_W-1:0] q_xz;
      logic signed [Q_W-1:0] q_yy;
      logic signed [Q_W-1:0] q_yz;
      logic signed [Q_W-1:0] q_zz;
      logic [CNT_W-1:0]      molecule_count;
      logic                  bad_site_count;
      logic                  zero_length_seen;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [REM_W-1:0]  rem_init;
      logic [DVD_W-1:0]  dividend;
      logic [REM_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUO_W-1:0]  quotient;
   } div_rsp_type;

   // Axis pairs of the six unique tensor components.
   function automatic logic [1:0] pair_a(input logic [2:0] j);
      logic [1:0] r;
      case (j)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_b(input logic [2:0] j);
      logic [1:0] r;
      case (j)
         3'd0:       r = 2'd0;
         3'd1, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

/* rtl/nematic_order_tensor_accumulator.sv */
// ----------------------------------------------------------------------------
// nematic_order_tensor_accumulator
// Groups mesogen sites into molecules, accumulates the nematic order tensor
// of each molecule's end-to-end unit vector and emits frame averages.
// ----------------------------------------------------------------------------
// A site that closes no molecule is taken while the block stays idle; one that
// closes a molecule holds the input for setup and six 32-step divisions, unless
// its ends coincide or the molecule count is full. A frame's last site adds six
// 49-step divisions plus setup and wrap-up, or only wrap-up with no molecules,
// before the result is valid. One site is in work at a time.
// Reset is synchronous: registers go to their reset values, frame state clears.
module nematic_order_tensor_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nota_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nota_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAG, ST_SQ_MUL, ST_SQ_ACC, ST_PR_MUL, ST_PR_DIV, ST_PR_WAIT,
      ST_AVG_PREP, ST_AVG_DIV, ST_AVG_WAIT, ST_FIN, ST_OUT
   } state_type;

   localparam int MW = nota_pkg::MAG_W;
   localparam int SW = nota_pkg::SUM_W;

   state_type state_ff, state_in;
   logic [7:0] mesogen_ff, mesogen_in;
   logic [7:0] group_ff, group_in;
   logic signed [31:0] first_ff [3];
   logic signed [31:0] first_in [3];
   logic signed [31:0] cur_ff [3];
   logic signed [31:0] cur_in [3];
   logic [7:0] site_ff, site_in;
   logic signed [SW-1:0] sum_ff [6];
   logic signed [SW-1:0] sum_in [6];
   logic [nota_pkg::CNT_W-1:0] mols_ff, mols_in;
   logic zero_ff, zero_in;
   logic last_ff, last_in;
   logic [MW-1:0] mag_x_ff, mag_y_ff, mag_z_ff, mag_x_in, mag_y_in, mag_z_in;
   logic [2:0] neg_ff, neg_in;
   logic [nota_pkg::REM_W-1:0] m2_ff, m2_in;
   logic [nota_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [2:0] idx_ff, idx_in;
   nota_pkg::rsp_type rsp_ff, rsp_in;

   nota_pkg::div_req_type div_req;
   nota_pkg::div_rsp_type div_rsp;

   logic        accept, csr_write;
   logic [32:0] dlt [3];
   logic [32:0] mag [3];
   logic [32:0] mx;
   logic [1:0]  shamt;
   logic [8:0]  next_site;
   logic [8:0]  group_eff;
   logic [1:0]  sel_a, sel_b;
   logic [MW-1:0] op_a, op_b;
   logic [32:0] rnd;
   logic signed [SW-1:0] term;
   logic signed [SW-1:0] cur_sum;
   logic [SW-1:0] sum_mag;
   logic [nota_pkg::DVD_W-1:0] avg_num;
   logic [nota_pkg::QUO_W-1:0] avg_q;

   function automatic logic [MW-1:0] sel3(input logic [1:0] k, input logic [MW-1:0] x,
                                          input logic [MW-1:0] y, input logic [MW-1:0] z);
      logic [MW-1:0] r;
      case (k)
         2'd0:    r = x;
         2'd1:    r = y;
         default: r = z;
      endcase
      return r;
   endfunction

   nota_serdiv u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept     = req_valid && !req_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         nota_pkg::REG_MESOGEN_TYPE:       csr_prdata = {24'd0, mesogen_ff};
         nota_pkg::REG_SITES_PER_MOLECULE: csr_prdata = {24'd0, group_ff};
      endcase
   end

   // End-to-end vector, magnitudes and common range-reduction shift.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dlt[j] = {first_ff[j][31], first_ff[j]} - {cur_ff[j][31], cur_ff[j]};
         mag[j] = dlt[j][32] ? -dlt[j] : dlt[j];
      end
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
      if (mx[32])      shamt = 2'd3;
      else if (mx[31]) shamt = 2'd2;
      else if (mx[30]) shamt = 2'd1;
      else             shamt = 2'd0;
   end

   always_comb begin
      sel_a   = (state_ff == ST_SQ_MUL) ? idx_ff[1:0] : nota_pkg::pair_a(idx_ff);
      sel_b   = (state_ff == ST_SQ_MUL) ? idx_ff[1:0] : nota_pkg::pair_b(idx_ff);
      op_a    = sel3(sel_a, mag_x_ff, mag_y_ff, mag_z_ff);
      op_b    = sel3(sel_b, mag_x_ff, mag_y_ff, mag_z_ff);
      // Quotient is floor(p * 2^31 / m); one more halving rounds ties up.
      rnd     = {1'b0, div_rsp.quotient} + 33'd1;
      term    = {{(SW-31){1'b0}}, rnd[31:1]};
      if (neg_ff[nota_pkg::pair_a(idx_ff)] ^ neg_ff[nota_pkg::pair_b(idx_ff)]) term = -term;
      if (nota_pkg::pair_a(idx_ff) == nota_pkg::pair_b(idx_ff))
         term = term - nota_pkg::ONE_THIRD_Q30;
      cur_sum = sum_ff[idx_ff];
      sum_mag = cur_sum[SW-1] ? -cur_sum : cur_sum;
      avg_num = {1'b0, sum_mag} + nota_pkg::DVD_W'(mols_ff >> 1);
      avg_q   = cur_sum[SW-1] ? -div_rsp.quotient : div_rsp.quotient;
      next_site = {1'b0, site_ff} + 9'd1;
      group_eff = (group_ff == 8'd0) ? 9'd1 : {1'b0, group_ff};
   end

   always_comb begin
      div_req = '0;
      if (state_ff == ST_PR_DIV) begin
         div_req.start    = 1'b1;
         div_req.rem_init = {3'd0, prod_ff[nota_pkg::PROD_W-1:1]};
         div_req.dividend = {prod_ff[0], {(nota_pkg::DVD_W-1){1'b0}}};
         div_req.divisor  = m2_ff;
         div_req.steps    = nota_pkg::RATIO_STEPS;
      end else if (state_ff == ST_AVG_DIV) begin
         div_req.start    = 1'b1;
         div_req.dividend = avg_num;
         div_req.divisor  = nota_pkg::REM_W'(mols_ff);
         div_req.steps    = nota_pkg::AVG_STEPS;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mesogen_in = mesogen_ff;
      group_in   = group_ff;
      first_in   = first_ff;
      cur_in     = cur_ff;
      site_in    = site_ff;
      sum_in     = sum_ff;
      mols_in    = mols_ff;
      zero_in    = zero_ff;
      last_in    = last_ff;
      mag_x_in   = mag_x_ff;
      mag_y_in   = mag_y_ff;
      mag_z_in   = mag_z_ff;
      neg_in     = neg_ff;
      m2_in      = m2_ff;
      prod_in    = prod_ff;
      idx_in     = idx_ff;
      rsp_in     = rsp_ff;

      if (csr_write) begin
         unique case (csr_paddr[2])
            nota_pkg::REG_MESOGEN_TYPE:       mesogen_in = csr_pwdata[7:0];
            nota_pkg::REG_SITES_PER_MOLECULE: group_in   = csr_pwdata[7:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req_data.last_in_frame;
               state_in = req_data.last_in_frame ? ST_AVG_PREP : ST_IDLE;
               if (req_data.site_type == mesogen_ff) begin
                  cur_in = '{req_data.pos_x, req_data.pos_y, req_data.pos_z};
                  if (site_ff == 8'd0)
                     first_in = '{req_data.pos_x, req_data.pos_y, req_data.pos_z};
                  if (next_site >= group_eff) begin
                     site_in = 8'd0;
                     if (mols_ff < nota_pkg::MAX_COUNT) begin
                        mols_in  = mols_ff + 1'b1;
                        state_in = ST_MAG;
                     end
                  end else begin
                     site_in = next_site[7:0];
                  end
               end
            end
         end
         ST_MAG: begin
            mag_x_in = MW'(mag[0] >> shamt);
            mag_y_in = MW'(mag[1] >> shamt);
            mag_z_in = MW'(mag[2] >> shamt);
            neg_in   = {dlt[2][32], dlt[1][32], dlt[0][32]};
            m2_in    = '0;
            idx_in   = 3'd0;
            if (mx == 33'd0) begin
               // Coincident ends: counted, but nothing is added to the sums.
               zero_in  = 1'b1;
               state_in = last_ff ? ST_AVG_PREP : ST_IDLE;
            end else begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            prod_in  = op_a * op_b;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            m2_in = m2_ff + nota_pkg::REM_W'(prod_ff);
            if (idx_ff == 3'd2) begin
               idx_in   = 3'd0;
               state_in = ST_PR_MUL;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_PR_MUL: begin
            prod_in  = op_a * op_b;
            state_in = ST_PR_DIV;
         end
         ST_PR_DIV: state_in = ST_PR_WAIT;
         ST_PR_WAIT: begin
            if (div_rsp.done) begin
               sum_in[idx_ff] = cur_sum + term;
               if (idx_ff == 3'd5) begin
                  state_in = last_ff ? ST_AVG_PREP : ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = ST_PR_MUL;
               end
            end
         end
         ST_AVG_PREP: begin
            idx_in = 3'd0;
            if (mols_ff == '0) begin
               rsp_in.q_xx = '0;
               rsp_in.q_xy = '0;
               rsp_in.q_xz = '0;
               rsp_in.q_yy = '0;
               rsp_in.q_yz = '0;
               rsp_in.q_zz = '0;
               state_in    = ST_FIN;
            end else begin
               state_in = ST_AVG_DIV;
            end
         end
         ST_AVG_DIV: state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               case (idx_ff)
                  3'd0:    rsp_in.q_xx = avg_q;
                  3'd1:    rsp_in.q_xy = avg_q;
                  3'd2:    rsp_in.q_xz = avg_q;
                  3'd3:    rsp_in.q_yy = avg_q;
                  3'd4:    rsp_in.q_yz = avg_q;
                  default: rsp_in.q_zz = avg_q;
               endcase
               if (idx_ff == 3'd5) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = ST_AVG_DIV;
               end
            end
         end
         ST_FIN: begin
            rsp_in.molecule_count   = mols_ff;
            rsp_in.bad_site_count   = site_ff != 8'd0;
            rsp_in.zero_length_seen = zero_ff;
            sum_in   = '{default: '0};
            site_in  = 8'd0;
            mols_in  = '0;
            zero_in  = 1'b0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      cur_ff   <= cur_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      neg_ff   <= neg_in;
      m2_ff    <= m2_in;
      prod_ff  <= prod_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         mesogen_ff <= nota_pkg::MESOGEN_RESET;
         group_ff   <= nota_pkg::GROUP_RESET;
         site_ff    <= 8'd0;
         sum_ff     <= '{default: '0};
         mols_ff    <= '0;
         zero_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mesogen_ff <= mesogen_in;
         group_ff   <= group_in;
         site_ff    <= site_in;
         sum_ff     <= sum_in;
         mols_ff    <= mols_in;
         zero_ff    <= zero_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_data.molecule_count <= nota_pkg::MAX_COUNT)
      else $error("molecule count above limit");
`endif

endmodule

/* rtl/nota_serdiv.sv */
// ----------------------------------------------------------------------------
// nota_serdiv
// Bit-serial restoring divider: one quotient bit per cycle. The remainder
// starts from a preset value and the dividend is shifted in MSB first.
// ----------------------------------------------------------------------------
module nota_serdiv (
   input  logic                  clock,
   input  logic                  reset,
   input  nota_pkg::div_req_type req,
   output nota_pkg::div_rsp_type rsp
);

   logic [nota_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [nota_pkg::REM_W-1:0]  den_ff, den_in;
   logic [nota_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [nota_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [nota_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [nota_pkg::REM_W:0]    trial;
   logic [nota_pkg::REM_W:0]    diff;
   logic                        fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[nota_pkg::DVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.rem_init;
         den_in  = req.divisor;
         dvd_in  = req.dividend;
         quo_in  = '0;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits back in REM_W bits.
         rem_in = fits ? diff[nota_pkg::REM_W-1:0] : trial[nota_pkg::REM_W-1:0];
         dvd_in = {dvd_ff[nota_pkg::DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[nota_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == nota_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
